// ===== src/mvc_pkg.sv =====
// Types, constants and microcode ROM for the multichannel volume control.
// No dependencies; imported by multichannel_volume_control.
`timescale 1ns / 1ps
`default_nettype none

package mvc_pkg;

  // Field widths
  localparam int LEVEL_W   = 16;
  localparam int STEP_W    = 18;
  localparam int PCTREG_W  = 7;
  localparam int REG_BITS  = 9;   // width of the present and mask vectors
  localparam int CH_W      = 4;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 4;

  // Datapath widths
  localparam int SUM_W  = 21;
  localparam int DSUM_W = 22;
  localparam int DEN_W  = 20;
  localparam int DVS_W  = 21;     // divisor, twice the denominator
  localparam int NUM_W  = 29;
  localparam int MAG_W  = 28;
  localparam int PROD_W = 43;
  localparam int MA_W   = 25;
  localparam int MB_W   = 18;
  localparam int XOFF_W = 24;
  localparam int Q_W    = 17;
  localparam int QUO_W  = 16;

  // Arithmetic constants
  localparam int PCT_SCALE   = 100;
  localparam int STEP_HALF   = 50;
  localparam int STEP_BIAS   = 65536;             // keeps the page step dividend positive
  localparam int STEP_OFS    = PCT_SCALE * STEP_BIAS;
  localparam int RECIP       = 41943;             // floor(2^22 / 100)
  localparam int RECIP_SHIFT = 22;
  localparam int PCT_MIN_REG = 1;
  localparam int PCT_MAX_REG = 99;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET_ALL    = 3'd0,
    OP_CHANGE_ALL = 3'd1,
    OP_SET_ONE    = 3'd2,
    OP_SET_SWITCH = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN     = 3'd0,
    REG_MAX     = 3'd1,
    REG_STEP    = 3'd2,
    REG_PRESENT = 3'd3
  } reg_idx_t;

  // Datapath actions, one per microcode step
  typedef enum logic [3:0] {
    U_INIT, U_UPD, U_ONE, U_SUM, U_CHAN, U_DIFF, U_NUM,
    U_NDEN, U_NORM, U_DSET, U_DIV, U_Q0, U_QFIX, U_FIN
  } uop_t;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT, C_NOT_BULK, C_CH_MORE, C_DIV_MORE, C_HOLD
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Jump targets
  localparam upc_t UA_UPD = 4'd1;
  localparam upc_t UA_ONE = 4'd2;
  localparam upc_t UA_SUM = 4'd3;
  localparam upc_t UA_DIV = 4'd10;

  // Microcode program
  function automatic uword_t ucode_rom(input upc_t a);
    uword_t w;
    unique case (a)
      4'd0:    w = uword_t'{U_INIT, C_NOT_BULK, UA_ONE};
      4'd1:    w = uword_t'{U_UPD,  C_CH_MORE,  UA_UPD};
      4'd2:    w = uword_t'{U_ONE,  C_NEXT,     UA_ONE};
      4'd3:    w = uword_t'{U_SUM,  C_CH_MORE,  UA_SUM};
      4'd4:    w = uword_t'{U_CHAN, C_NEXT,     UA_ONE};
      4'd5:    w = uword_t'{U_DIFF, C_NEXT,     UA_ONE};
      4'd6:    w = uword_t'{U_NUM,  C_NEXT,     UA_ONE};
      4'd7:    w = uword_t'{U_NDEN, C_NEXT,     UA_ONE};
      4'd8:    w = uword_t'{U_NORM, C_NEXT,     UA_ONE};
      4'd9:    w = uword_t'{U_DSET, C_NEXT,     UA_ONE};
      4'd10:   w = uword_t'{U_DIV,  C_DIV_MORE, UA_DIV};
      4'd11:   w = uword_t'{U_Q0,   C_NEXT,     UA_ONE};
      4'd12:   w = uword_t'{U_QFIX, C_NEXT,     UA_ONE};
      default: w = uword_t'{U_FIN,  C_HOLD,     UA_ONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/multichannel_volume_control.sv =====
// Multichannel volume control: level store, microcoded sequencer and datapath.
// Depends on mvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Keeps one signed 16-bit volume per channel and a switch flag. Each input
// transfer carries one operation (op in s_tuser); after it is applied one
// result transfer reports the chosen channel's level, that level gated by the
// switch, the rounded average percent over the masked present channels and
// the page step. One item is worked on at a time; how long it takes is set
// by the walks through the level store, one channel a cycle, twice for
// set-all and change-all and once for the other operations, and by the
// sixteen-step restoring divider for the percent. The next item is taken as
// soon as the result sits in the output register.
// Configuration writes are accepted at any time but must only be issued
// while no item is outstanding. No clearing pass follows reset.
module multichannel_volume_control
  import mvc_pkg::*;
#(
  parameter int NUM_CHANNELS = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // channel[3:0], level[19:4], go_down[20],
                                      // avg_mask[29:21], switch_value[30], zero[31]
  input  wire logic [2:0]  s_tuser,   // op[2:0]
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // channel_level[15:0], shown_level[31:16],
                                      // avg_percent[47:32], page_step[65:48], zero[71:66]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LEV_DEPTH = 1 << IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);
  localparam logic [3:0] DIV_LAST = 4'(QUO_W - 1);

  // Sequencer and handshake state
  logic busy;
  upc_t upc;
  uword_t uw;

  // Configuration and stored state
  logic signed [LEVEL_W-1:0]  min_level;
  logic signed [LEVEL_W-1:0]  max_level;
  logic [PCTREG_W-1:0]        step_percent;
  logic [REG_BITS-1:0]        present_channels;
  logic                       switch_on;
  logic signed [LEVEL_W-1:0]  lev [LEV_DEPTH];

  // Latched item
  logic [OP_W-1:0]            op_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [LEVEL_W-1:0]  level_r;
  logic                       down_r;
  logic [REG_BITS-1:0]        mask_r;
  logic                       swv_r;

  // Datapath registers
  logic [IDX_W-1:0]           idx;
  logic signed [LEVEL_W-1:0]  vclamp;
  logic signed [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]           cnt;
  logic signed [LEVEL_W-1:0]  chl;
  logic signed [PROD_W-1:0]   prod;
  logic signed [DSUM_W-1:0]   dsum;
  logic [DEN_W-1:0]           den;
  logic signed [NUM_W-1:0]    n_r;
  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic [DVS_W-1:0]           divisor;
  logic [XOFF_W-1:0]          xoff;
  logic                       ovf;
  logic [DVS_W-1:0]           rem;
  logic [QUO_W-1:0]           quo;
  logic [3:0]                 dcnt;
  logic [Q_W-1:0]             q0;
  logic [Q_W-1:0]             stepq;

  // Combinational nets
  logic [LEV_DEPTH-1:0]       present_vec;
  logic [LEV_DEPTH-1:0]       mask_vec;
  logic [LEV_DEPTH-1:0]       cfg_pres_vec;
  logic                       ch_ok;
  logic [IDX_W-1:0]           ch_idx;
  logic [IDX_W-1:0]           rd_addr;
  logic signed [LEVEL_W-1:0]  lev_rd;
  logic signed [LEVEL_W:0]    clamp_in;
  logic signed [LEVEL_W-1:0]  clamp_out;
  logic                       is_bulk;
  logic                       idx_last;
  logic [CNT_W-1:0]           cnt_eff;
  logic signed [LEVEL_W:0]    diff;
  logic signed [LEVEL_W+1:0]  span;
  logic signed [MA_W-1:0]     ma;
  logic signed [MB_W-1:0]     mb;
  logic signed [NUM_W-1:0]    n_val;
  logic signed [PROD_W-1:0]   xoff_calc;
  logic [DVS_W:0]             dtrial;
  logic [DVS_W:0]             dsub;
  logic                       dge;
  logic [XOFF_W-1:0]          hq;
  logic [XOFF_W-1:0]          rq;
  logic                       flat;
  logic [QUO_W:0]             pm;
  logic signed [LEVEL_W-1:0]  pct;
  logic signed [STEP_W-1:0]   st0;
  logic signed [STEP_W-1:0]   st1;
  logic signed [STEP_W-1:0]   stv;
  logic signed [LEVEL_W-1:0]  shown;
  logic                       out_free;
  logic                       s_acc;
  logic                       cfg_acc;

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;
  assign uw        = ucode_rom(upc);

  // Present and mask bits per store entry; entries past the channel count or the register width are absent
  for (genvar g = 0; g < LEV_DEPTH; g++) begin : g_vec
    if (g < NUM_CHANNELS && g < REG_BITS) begin : g_real
      assign present_vec[g]  = present_channels[g];
      assign mask_vec[g]     = mask_r[g];
      assign cfg_pres_vec[g] = cfg_data[g];
    end else begin : g_absent
      assign present_vec[g]  = 1'b0;
      assign mask_vec[g]     = 1'b0;
      assign cfg_pres_vec[g] = 1'b0;
    end
  end

  // Level store read port and clamp unit
  assign ch_idx   = ch_r[IDX_W-1:0];
  assign ch_ok    = ({1'b0, ch_r} < 5'(NUM_CHANNELS)) && present_vec[ch_idx];
  assign rd_addr  = (uw.uop == U_CHAN) ? ch_idx : idx;
  assign lev_rd   = lev[rd_addr];
  assign is_bulk  = (op_r == OP_SET_ALL) || (op_r == OP_CHANGE_ALL);
  assign idx_last = (idx == IDX_LAST);
  assign cnt_eff  = (cnt == '0) ? CNT_W'(1) : cnt;

  always_comb begin
    if (uw.uop == U_INIT) begin
      clamp_in = (LEVEL_W+1)'(level_r);
    end else begin
      clamp_in = (LEVEL_W+1)'(lev_rd) + (LEVEL_W+1)'(level_r);
    end
    if (clamp_in < (LEVEL_W+1)'(min_level)) begin
      clamp_out = min_level;
    end else if (clamp_in < (LEVEL_W+1)'(max_level)) begin
      clamp_out = clamp_in[LEVEL_W-1:0];
    end else begin
      clamp_out = max_level;
    end
  end

  assign diff = (LEVEL_W+1)'(max_level) - (LEVEL_W+1)'(min_level);
  assign span = (LEVEL_W+2)'(diff) + (LEVEL_W+2)'(1);

  // Shared multiplier operand selection
  always_comb begin
    unique case (uw.uop)
      U_CHAN: begin
        ma = MA_W'(min_level);
        mb = MB_W'(cnt_eff);
      end
      U_DIFF: begin
        ma = MA_W'(diff);
        mb = MB_W'(cnt);
      end
      U_NUM: begin
        ma = MA_W'(dsum);
        mb = MB_W'(PCT_SCALE);
      end
      U_NDEN: begin
        ma = MA_W'(span);
        mb = MB_W'(step_percent);
      end
      U_DSET: begin
        ma = MA_W'(xoff);
        mb = MB_W'(RECIP);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Numerator 2*num+den, page step dividend offset, divider step
  assign n_val     = (NUM_W'($signed(prod[26:0])) <<< 1) + NUM_W'(den);
  assign xoff_calc = prod + PROD_W'(STEP_HALF + STEP_OFS);
  assign dtrial    = {rem, quo[QUO_W-1]};
  assign dge       = dtrial >= {1'b0, divisor};
  assign dsub      = dtrial - {1'b0, divisor};

  // Page step correction: remainder of the reciprocal estimate
  assign hq = (XOFF_W'(q0) << 6) + (XOFF_W'(q0) << 5) + (XOFF_W'(q0) << 2);
  assign rq = xoff - hq;

  // Result formatting
  assign flat = (max_level <= min_level);
  assign pm   = {1'b0, quo} + (QUO_W+1)'(rem != '0);

  always_comb begin
    if (flat) begin
      pct = '0;
    end else if (ovf) begin
      pct = neg ? $signed(16'h8000) : $signed(16'h7FFF);
    end else if (!neg) begin
      pct = quo[QUO_W-1] ? $signed(16'h7FFF) : $signed(quo);
    end else if (pm > (QUO_W+1)'(32768)) begin
      pct = $signed(16'h8000);
    end else begin
      pct = $signed(pm[LEVEL_W-1:0]);
      pct = -pct;
    end
  end

  assign st0   = $signed({1'b0, stepq}) - STEP_W'(STEP_BIAS);
  assign st1   = (st0 == '0) ? STEP_W'(1) : st0;
  assign stv   = down_r ? -st1 : st1;
  assign shown = switch_on ? chl : '0;

  // Control, configuration, level store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      upc              <= '0;
      m_tvalid         <= 1'b0;
      min_level        <= '0;
      max_level        <= '0;
      step_percent     <= PCTREG_W'(5);
      present_channels <= '0;
      switch_on        <= 1'b1;
      for (int i = 0; i < LEV_DEPTH; i++) begin
        lev[i] <= '0;
      end
    end else begin
      // a result leaving while the next one loads keeps tvalid high
      if (m_tvalid && m_tready && !(busy && uw.cond == C_HOLD)) begin
        m_tvalid <= 1'b0;
      end

      // configuration writes
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_MIN: min_level <= $signed(cfg_data);
          REG_MAX: max_level <= $signed(cfg_data);
          REG_STEP: begin
            if (cfg_data[PCTREG_W-1:0] >= PCTREG_W'(PCT_MIN_REG) &&
                cfg_data[PCTREG_W-1:0] <= PCTREG_W'(PCT_MAX_REG)) begin
              step_percent <= cfg_data[PCTREG_W-1:0];
            end
          end
          REG_PRESENT: begin
            present_channels <= cfg_data[REG_BITS-1:0];
            // a channel that leaves comes back at zero
            for (int i = 0; i < LEV_DEPTH; i++) begin
              if (!cfg_pres_vec[i]) begin
                lev[i] <= '0;
              end
            end
          end
          default: ;
        endcase
      end

      if (s_acc) begin
        busy <= 1'b1;
        upc  <= '0;
      end else if (busy) begin
        // sequencing
        unique case (uw.cond)
          C_NEXT:     upc <= upc + 4'd1;
          C_NOT_BULK: upc <= is_bulk ? upc + 4'd1 : uw.target;
          C_CH_MORE:  upc <= idx_last ? upc + 4'd1 : uw.target;
          C_DIV_MORE: upc <= (dcnt == DIV_LAST) ? upc + 4'd1 : uw.target;
          C_HOLD: begin
            if (out_free) begin
              busy     <= 1'b0;
              m_tvalid <= 1'b1;
              m_tdata  <= {6'b0, stv, pct, shown, chl};
            end
          end
          default: ;
        endcase

        // level store and switch updates
        if (uw.uop == U_UPD && present_vec[idx]) begin
          lev[idx] <= (op_r == OP_SET_ALL) ? vclamp : clamp_out;
        end
        if (uw.uop == U_ONE) begin
          if (op_r == OP_SET_ONE && ch_ok) begin
            lev[ch_idx] <= level_r;
          end
          if (op_r == OP_SET_SWITCH) begin
            switch_on <= swv_r;
          end
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      op_r    <= s_tuser;
      ch_r    <= s_tdata[3:0];
      level_r <= $signed(s_tdata[19:4]);
      down_r  <= s_tdata[20];
      mask_r  <= s_tdata[29:21];
      swv_r   <= s_tdata[30];
    end
    if (busy) begin
      unique case (uw.uop)
        U_INIT: begin
          vclamp <= clamp_out;
          idx    <= '0;
          sum    <= '0;
          cnt    <= '0;
        end
        U_UPD: idx <= idx_last ? '0 : idx + IDX_W'(1);
        U_ONE: idx <= '0;
        U_SUM: begin
          if (present_vec[idx] && mask_vec[idx]) begin
            sum <= sum + SUM_W'(lev_rd);
            cnt <= cnt + CNT_W'(1);
          end
          idx <= idx_last ? '0 : idx + IDX_W'(1);
        end
        U_CHAN: begin
          chl  <= ch_ok ? lev_rd : '0;
          cnt  <= cnt_eff;
          prod <= ma * mb;
        end
        U_DIFF: begin
          dsum <= DSUM_W'(sum) - $signed(prod[DSUM_W-1:0]);
          prod <= ma * mb;
        end
        U_NUM: begin
          den  <= prod[DEN_W-1:0];
          prod <= ma * mb;
        end
        U_NDEN: begin
          n_r     <= n_val;
          divisor <= {den, 1'b0};
          prod    <= ma * mb;
        end
        U_NORM: begin
          neg  <= n_r[NUM_W-1];
          mag  <= n_r[NUM_W-1] ? MAG_W'(-n_r) : MAG_W'(n_r);
          xoff <= xoff_calc[XOFF_W-1:0];
        end
        U_DSET: begin
          ovf  <= {9'b0, mag} >= {divisor, 16'b0};
          rem  <= DVS_W'(mag[MAG_W-1:QUO_W]);
          quo  <= mag[QUO_W-1:0];
          dcnt <= '0;
          prod <= ma * mb;
        end
        U_DIV: begin
          rem  <= dge ? dsub[DVS_W-1:0] : dtrial[DVS_W-1:0];
          quo  <= {quo[QUO_W-2:0], dge};
          dcnt <= dcnt + 4'd1;
        end
        U_Q0:   q0 <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        U_QFIX: stepq <= (rq >= XOFF_W'(PCT_SCALE)) ? q0 + Q_W'(1) : q0;
        default: ;
      endcase
    end
  end

  // An accepted item starts the program from its first step
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> busy && upc == '0)
    else $error("item accepted without starting the sequencer");

  // The final step hands the result to a free output register and goes idle
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && uw.cond == C_HOLD && out_free |=> m_tvalid && !busy)
    else $error("result not loaded at the end of the program");

  // Restoring divider keeps its partial remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    busy && uw.uop == U_DIV && !ovf && divisor != '0 |-> rem < divisor)
    else $error("divider remainder out of range");

  // Channel count for the average is never zero and never above the register width
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    busy && uw.uop == U_FIN |-> cnt != '0 && cnt <= CNT_W'(REG_BITS))
    else $error("average channel count out of range");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for multichannel_volume_control: directed and random command streams
// checked against a behavioural volume store. Depends on mvc_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
  import mvc_pkg::*;

  localparam int N_CH        = 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PAD    = 50;    // above the longest item latency
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 62;

  // Codes outside the defined sets; the block treats them as query / no-op
  localparam logic [OP_W-1:0]      OP_RESERVED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd5;

  typedef struct packed {
    logic signed [17:0] step;
    logic signed [15:0] pct;
    logic signed [15:0] shown;
    logic signed [15:0] chl;
  } vol_report_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predicted block state
  longint      vol_store [N_CH];
  bit          switch_state;
  longint      lo_level;
  longint      hi_level;
  longint      page_pct;
  logic [8:0]  present_mask;

  vol_report_t pending_reports [$];
  int          error_count;
  int          cycle_count;
  bit          src_gaps;
  bit          sink_stalls;
  int          stall_left;

  multichannel_volume_control #(
    .NUM_CHANNELS(N_CH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural volume store
  // ---------------------------------------------------------------------------

  function automatic longint div_down(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0)))
      q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_to_range(input longint v);
    if (v < lo_level)
      return lo_level;
    if (v < hi_level)
      return v;
    return hi_level;
  endfunction

  function automatic bit is_live(input int c);
    if (c >= N_CH)
      return 1'b0;
    return present_mask[c];
  endfunction

  task automatic reset_volume_model();
    lo_level     = 0;
    hi_level     = 0;
    page_pct     = 5;
    present_mask = '0;
    switch_state = 1'b1;
    for (int i = 0; i < N_CH; i++)
      vol_store[i] = 0;
  endtask

  task automatic apply_reg_write(input logic [2:0] idx, input logic [15:0] d);
    case (idx)
      REG_MIN:  lo_level = longint'($signed(d));
      REG_MAX:  hi_level = longint'($signed(d));
      REG_STEP: begin
        if (d[6:0] >= PCT_MIN_REG && d[6:0] <= PCT_MAX_REG)
          page_pct = longint'(d[6:0]);
      end
      REG_PRESENT: begin
        present_mask = d[8:0];
        // a channel that leaves comes back at zero
        for (int i = 0; i < N_CH; i++)
          if (!is_live(i))
            vol_store[i] = 0;
      end
      default: ;
    endcase
  endtask

  task automatic apply_volume_cmd(input logic [2:0] op, input logic [3:0] ch,
                                  input logic signed [15:0] lvl, input logic down,
                                  input logic [8:0] mask, input logic sw,
                                  output vol_report_t r);
    longint chl, sum, cnt, num, den, pct, span, stepv;
    case (op)
      OP_SET_ALL: begin
        for (int i = 0; i < N_CH; i++)
          if (is_live(i))
            vol_store[i] = clamp_to_range(longint'(lvl));
      end
      OP_CHANGE_ALL: begin
        for (int i = 0; i < N_CH; i++)
          if (is_live(i))
            vol_store[i] = clamp_to_range(vol_store[i] + longint'(lvl));
      end
      OP_SET_ONE: begin
        if (is_live(int'(ch)))
          vol_store[ch] = longint'(lvl);
      end
      OP_SET_SWITCH: switch_state = sw;
      default: ;
    endcase

    chl = is_live(int'(ch)) ? vol_store[ch] : 0;

    // average position in percent, half-up rounding
    if (hi_level <= lo_level) begin
      pct = 0;
    end else begin
      sum = 0;
      cnt = 0;
      for (int i = 0; i < N_CH; i++) begin
        if (is_live(i) && mask[i]) begin
          sum += vol_store[i];
          cnt++;
        end
      end
      if (cnt == 0) begin
        sum = 0;
        cnt = 1;
      end
      num = 100 * (sum - lo_level * cnt);
      den = cnt * (hi_level - lo_level);
      pct = div_down(2 * num + den, 2 * den);
      if (pct > 32767)
        pct = 32767;
      if (pct < -32768)
        pct = -32768;
    end

    span  = hi_level - lo_level + 1;
    stepv = div_down(span * page_pct + 50, 100);
    if (stepv == 0)
      stepv = 1;
    if (down)
      stepv = -stepv;

    r.chl   = chl[15:0];
    r.shown = switch_state ? chl[15:0] : 16'sd0;
    r.pct   = pct[15:0];
    r.step  = stepv[17:0];
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    vol_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with nothing outstanding, channel_level",
                      longint'($signed(m_tdata[15:0])), 0);
      end else begin
        want = pending_reports.pop_front();
        if ($signed(m_tdata[15:0]) !== want.chl)
          flag_mismatch("channel_level", longint'($signed(m_tdata[15:0])),
                        longint'(want.chl));
        if ($signed(m_tdata[31:16]) !== want.shown)
          flag_mismatch("shown_level", longint'($signed(m_tdata[31:16])),
                        longint'(want.shown));
        if ($signed(m_tdata[47:32]) !== want.pct)
          flag_mismatch("avg_percent", longint'($signed(m_tdata[47:32])),
                        longint'(want.pct));
        if ($signed(m_tdata[65:48]) !== want.step)
          flag_mismatch("page_step", longint'($signed(m_tdata[65:48])),
                        longint'(want.step));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result-side back-pressure in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_tready   = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic send_cmd(input logic [2:0] op, input logic [3:0] ch,
                          input logic [15:0] lvl, input logic down,
                          input logic [8:0] mask, input logic sw);
    vol_report_t r;
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      s_tvalid = 1'b0;
      // sometimes hold the gap until the block has just gone idle
      if ($urandom_range(0, 1) == 0)
        while (pending_reports.size() != 0)
          @(negedge clk);
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tuser  = op;
    s_tdata  = {1'b0, sw, mask, down, lvl, ch};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    apply_volume_cmd(op, ch, lvl, down, mask, sw, r);
    pending_reports.push_back(r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_block();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_reports.size() != 0)
      @(negedge clk);
    repeat (IDLE_PAD) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Nothing present after reset: zeros everywhere, page step of one
  task automatic test_reset_values();
    send_cmd(OP_QUERY, 4'd0, 16'h0000, 1'b0, 9'h1FF, 1'b0);
    send_cmd(OP_SET_ONE, 4'd4, 16'h1234, 1'b1, 9'h1FF, 1'b0);
    send_cmd(OP_SET_ALL, 4'd8, 16'h7FFF, 1'b0, 9'h000, 1'b1);
    drain_block();
  endtask

  task automatic test_directed_ops();
    write_reg(REG_MIN, -16'sd100);
    write_reg(REG_MAX, 16'sd100);
    write_reg(REG_STEP, 16'd99);
    write_reg(REG_PRESENT, 16'h01FF);
    // clamping at both ends, change-all up and down
    send_cmd(OP_QUERY,      4'd0, 16'h0000, 1'b0, 9'h1FF, 1'b0);
    send_cmd(OP_SET_ALL,    4'd8, 16'h7FFF, 1'b0, 9'h1FF, 1'b0);
    send_cmd(OP_SET_ALL,    4'd0, 16'h8000, 1'b1, 9'h1FF, 1'b0);
    send_cmd(OP_CHANGE_ALL, 4'd1, 16'd50,   1'b0, 9'h0AA, 1'b0);
    send_cmd(OP_CHANGE_ALL, 4'd2, 16'h8000, 1'b0, 9'h155, 1'b0);
    send_cmd(OP_CHANGE_ALL, 4'd7, 16'h7FFF, 1'b1, 9'h1FF, 1'b0);
    // set-one is not clamped; channels at or past nine are absent
    send_cmd(OP_SET_ONE,    4'd3, 16'h8000, 1'b0, 9'h008, 1'b0);
    send_cmd(OP_SET_ONE,    4'd15, 16'h04D2, 1'b0, 9'h1FF, 1'b1);
    send_cmd(OP_SET_ONE,    4'd9, 16'h0123, 1'b1, 9'h1FF, 1'b1);
    // switch gating, reserved op acts as a query
    send_cmd(OP_SET_SWITCH, 4'd3, 16'h0000, 1'b0, 9'h1FF, 1'b0);
    send_cmd(OP_QUERY,      4'd3, 16'hFFFF, 1'b1, 9'h1FF, 1'b1);
    send_cmd(OP_RESERVED,   4'd3, 16'h5555, 1'b0, 9'h1FF, 1'b1);
    send_cmd(OP_SET_SWITCH, 4'd3, 16'h0000, 1'b0, 9'h1FF, 1'b1);
    send_cmd(OP_QUERY,      4'd3, 16'h0000, 1'b0, 9'h000, 1'b0);
    drain_block();

    // narrow range: percent saturates both ways; leaving channels are cleared
    write_reg(REG_MIN, 16'd0);
    write_reg(REG_MAX, 16'd1);
    write_reg(REG_STEP, 16'd1);
    write_reg(REG_PRESENT, 16'h000F);
    send_cmd(OP_SET_ONE, 4'd0, 16'h7FFF, 1'b0, 9'h001, 1'b0);
    send_cmd(OP_SET_ONE, 4'd1, 16'h8000, 1'b1, 9'h002, 1'b0);
    send_cmd(OP_QUERY,   4'd5, 16'h0000, 1'b0, 9'h1F0, 1'b0);
    drain_block();

    // inverted range, rejected step writes, unknown register
    write_reg(REG_MIN, 16'h7FFF);
    write_reg(REG_MAX, 16'h8000);
    write_reg(REG_STEP, 16'd0);
    write_reg(REG_STEP, 16'd100);
    write_reg(REG_STEP, 16'hFF7F);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_cmd(OP_SET_ALL,    4'd2, 16'h0000, 1'b1, 9'h00F, 1'b0);
    send_cmd(OP_CHANGE_ALL, 4'd2, 16'hFFFF, 1'b0, 9'h00F, 1'b0);
    drain_block();

    // full range: largest span and page step, overflow in change-all
    write_reg(REG_MIN, 16'h8000);
    write_reg(REG_MAX, 16'h7FFF);
    write_reg(REG_STEP, 16'hFFE3);
    write_reg(REG_PRESENT, 16'hFFFF);
    send_cmd(OP_SET_ALL,    4'd8, 16'h7FFF, 1'b1, 9'h1FF, 1'b0);
    send_cmd(OP_CHANGE_ALL, 4'd8, 16'h7FFF, 1'b0, 9'h1FF, 1'b0);
    send_cmd(OP_SET_ALL,    4'd0, 16'h8000, 1'b0, 9'h1FF, 1'b0);
    send_cmd(OP_CHANGE_ALL, 4'd0, 16'h8000, 1'b1, 9'h1FF, 1'b0);
    drain_block();
  endtask

  task automatic pick_settings(input int phase);
    int          kind;
    int          a;
    int          b;
    int          t;
    logic [15:0] d;
    kind = (phase == 0) ? 0 : (phase == 1) ? 3 : $urandom_range(0, 4);
    a = $urandom_range(0, 65535) - 32768;
    b = $urandom_range(0, 65535) - 32768;
    case (kind)
      0: begin
        a = -32768;
        b = 32767;
      end
      1, 3: begin
        if (a > b) begin
          t = a; a = b; b = t;
        end
        if (kind == 3) begin
          t = a; a = b; b = t;
        end
      end
      2: begin
        a = $urandom_range(0, 65534) - 32768;
        b = a + $urandom_range(0, 1);
      end
      default: ;
    endcase
    write_reg(REG_MIN, a[15:0]);
    write_reg(REG_MAX, b[15:0]);

    // step percent, sometimes preceded by a rejected value
    if ($urandom_range(0, 3) == 0) begin
      d = 16'($urandom);
      d[6:0] = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(100, 127));
      write_reg(REG_STEP, d);
    end
    d = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       d[6:0] = 7'(PCT_MIN_REG);
      1:       d[6:0] = 7'(PCT_MAX_REG);
      default: d[6:0] = 7'($urandom_range(PCT_MIN_REG, PCT_MAX_REG));
    endcase
    write_reg(REG_STEP, d);

    if ($urandom_range(0, 3) == 0)
      write_reg(3'($urandom_range(4, 7)), 16'($urandom));

    d = 16'($urandom);
    case ($urandom_range(0, 7))
      0, 1, 2: d[8:0] = 9'h1FF;
      3:       d[8:0] = 9'h000;
      default: ;
    endcase
    write_reg(REG_PRESENT, d);
  endtask

  task automatic random_cmd();
    logic [2:0]  op;
    logic [3:0]  ch;
    logic [15:0] lvl;
    logic [8:0]  mask;
    int          sel;
    sel = $urandom_range(0, 15);
    if (sel < 3)
      op = OP_SET_ALL;
    else if (sel < 7)
      op = OP_CHANGE_ALL;
    else if (sel < 11)
      op = OP_SET_ONE;
    else if (sel < 13)
      op = OP_SET_SWITCH;
    else if (sel < 15)
      op = OP_QUERY;
    else
      op = 3'($urandom_range(5, 7));

    ch = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));

    lvl = 16'($urandom);
    case ($urandom_range(0, 7))
      0: lvl = 16'h7FFF;
      1: lvl = 16'h8000;
      2, 3: begin
        if (op == OP_CHANGE_ALL)
          lvl = 16'($urandom_range(0, 200) - 100);
        else if (hi_level >= lo_level)
          lvl = 16'(lo_level + $urandom_range(0, int'(hi_level - lo_level)));
      end
      4: lvl = 16'($urandom_range(0, 10) - 5);
      default: ;
    endcase

    mask = 9'($urandom);
    case ($urandom_range(0, 7))
      0:       mask = 9'h1FF;
      1:       mask = 9'h000;
      default: ;
    endcase

    send_cmd(op, ch, lvl, 1'($urandom), mask, 1'($urandom));
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RAND_PHASES; p++) begin
      pick_settings(p);
      // idling on most phases, none in the closing ones
      src_gaps    = (p < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      sink_stalls = (p < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        random_cmd();
      drain_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    m_tready    = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    error_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    reset_volume_model();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed_ops();
    test_random_traffic();

    if (pending_reports.size() != 0)
      flag_mismatch("results never delivered", 0, longint'(pending_reports.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
